>>> hdl/gear_hash_chunk_boundary_macros.svh
// ----------------------------------------------------------------------------
// gear hash chunk boundary assertion macros
// shared property forms used by the chunker top level
// ----------------------------------------------------------------------------
`ifndef GEAR_HASH_CHUNK_BOUNDARY_MACROS_SVH
`define GEAR_HASH_CHUNK_BOUNDARY_MACROS_SVH

// same-cycle implication, checked outside reset
`define GHCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GHCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ghcb_pkg.sv
// ----------------------------------------------------------------------------
// ghcb_pkg
// types, constants and the gear table for the content-defined chunker
// ----------------------------------------------------------------------------
package ghcb_pkg;

    localparam int LENGTH_BITS  = 32;
    localparam int HASH_W       = 64;
    localparam int GEAR_SIZE    = 256;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int LEAD_ZEROS_W = 6;
    localparam int OUT_LEN_W    = 32;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [HASH_W-1:0] GEAR_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_W-1:0] GEAR_MIX1   = 64'hBF58476D1CE4E5B9;
    localparam logic [HASH_W-1:0] GEAR_MIX2   = 64'h94D049BB133111EB;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_ZEROS = 2'd2;

    localparam logic [31:0] RST_MIN_LENGTH = 32'd1048576;
    localparam logic [31:0] RST_MAX_LENGTH = 32'd16777216;
    localparam logic [LEAD_ZEROS_W-1:0] RST_LEAD_ZEROS = 6'd22;

    typedef logic [HASH_W-1:0] gear_table_t [GEAR_SIZE];

    // queue entry: table value already looked up by the front
    typedef struct packed {
        logic [HASH_W-1:0] gear_val;
        logic              restart;
    } entry_t;

    typedef struct packed {
        logic [31:0]             min_length;
        logic [31:0]             max_length;
        logic [LEAD_ZEROS_W-1:0] lead_zeros;
    } cfg_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic not_empty;
    } q_ctrl_t;

    // splitmix64 sequence, evaluated at elaboration only
    function automatic gear_table_t build_gear();
        logic [HASH_W-1:0] s;
        logic [HASH_W-1:0] z;
        gear_table_t       t;
        s = GEAR_GOLDEN;
        for (int k = 0; k < GEAR_SIZE; k++)
        begin
            s = s + GEAR_GOLDEN;
            z = s;
            z = (z ^ (z >> 30)) * GEAR_MIX1;
            z = (z ^ (z >> 27)) * GEAR_MIX2;
            t[k] = z ^ (z >> 31);
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_TABLE = build_gear();

endpackage

>>> hdl/ghcb_if.sv
// ----------------------------------------------------------------------------
// ghcb interfaces
// valid/ready channels for bytes, results and register writes
// ----------------------------------------------------------------------------
interface ghcb_byte_if;
    logic                         valid;
    logic                         ready;
    logic [ghcb_pkg::BYTE_W-1:0]  data_byte;
    logic                         restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface ghcb_result_if;
    logic                           valid;
    logic                           ready;
    logic                           cut;
    logic [ghcb_pkg::OUT_LEN_W-1:0] chunk_length;

    modport source (output valid, output cut, output chunk_length, input ready);
    modport sink   (input valid, input cut, input chunk_length, output ready);
endinterface

interface ghcb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ghcb_pkg::CFG_IDX_W-1:0]  index;
    logic [ghcb_pkg::CFG_DATA_W-1:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

>>> hdl/gear_hash_chunk_boundary.sv
// ----------------------------------------------------------------------------
// gear_hash_chunk_boundary
// gear rolling-hash content-defined chunker, one byte per transaction
// ----------------------------------------------------------------------------
// channel  role   payload
// data     sink   data_byte[7:0], restart
// result   source cut, chunk_length[31:0]
// cfg      sink   index[1:0], value[31:0] (min_length, max_length, lead_zeros)
//
// one byte per cycle sustained while result.ready holds; the gear lookup lands in
// the queue at the transaction edge, the hash add and cut compare land in the
// output register at the edge on which the back pops the queue
// reset clears hash, length, queue and output; registers return to defaults
// a stalled result lets the two-entry queue fill before data.ready drops
// cfg.ready is always high
// ----------------------------------------------------------------------------
`include "gear_hash_chunk_boundary_macros.svh"

module gear_hash_chunk_boundary
(
    input  logic         clk,
    input  logic         rst_n,
    ghcb_byte_if.sink    data,
    ghcb_result_if.source result,
    ghcb_cfg_if.sink     cfg
);

    ghcb_pkg::cfg_t    cfg_reg, cfg_next;
    ghcb_pkg::entry_t  wr_entry, rd_entry;
    ghcb_pkg::q_ctrl_t q_ctrl;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                ghcb_pkg::CFG_MIN_LENGTH: cfg_next.min_length = cfg.value;
                ghcb_pkg::CFG_MAX_LENGTH: cfg_next.max_length = cfg.value;
                ghcb_pkg::CFG_LEAD_ZEROS:
                    cfg_next.lead_zeros = cfg.value[ghcb_pkg::LEAD_ZEROS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= ghcb_pkg::RST_MIN_LENGTH;
            cfg_reg.max_length <= ghcb_pkg::RST_MAX_LENGTH;
            cfg_reg.lead_zeros <= ghcb_pkg::RST_LEAD_ZEROS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ghcb_front u_front
    (
        .data   (data),
        .q_full (q_ctrl.full),
        .push   (q_ctrl.push),
        .entry  (wr_entry)
    );

    ghcb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_ctrl.push),
        .wr_entry  (wr_entry),
        .pop       (q_ctrl.pop),
        .rd_entry  (rd_entry),
        .full      (q_ctrl.full),
        .not_empty (q_ctrl.not_empty)
    );

    ghcb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_ctrl.not_empty),
        .entry       (rd_entry),
        .pop         (q_ctrl.pop),
        .result      (result)
    );

    `GHCB_ASSERT_SAME(a_len_nonzero, result.valid, result.chunk_length != '0, "zero chunk length")
    `GHCB_ASSERT_NEXT(a_push_lands, q_ctrl.push && !q_ctrl.not_empty, q_ctrl.not_empty, "push lost")
    `GHCB_ASSERT_NEXT(a_back_drains, q_ctrl.not_empty && !result.valid, result.valid, "queue stuck")

endmodule

>>> hdl/ghcb_front.sv
// ----------------------------------------------------------------------------
// ghcb_front
// accepts bytes and looks up their gear value for the queue
// ----------------------------------------------------------------------------
module ghcb_front
(
    ghcb_byte_if.sink        data,
    input  logic             q_full,
    output logic             push,
    output ghcb_pkg::entry_t entry
);

    assign data.ready = !q_full;
    assign push       = data.valid && !q_full;

    always_comb
    begin
        entry.gear_val = ghcb_pkg::GEAR_TABLE[data.data_byte];
        entry.restart  = data.restart;
    end

endmodule

>>> hdl/ghcb_queue.sv
// ----------------------------------------------------------------------------
// ghcb_queue
// two-entry queue between the lookup front and the hash back
// ----------------------------------------------------------------------------
module ghcb_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ghcb_pkg::entry_t wr_entry,
    input  logic             pop,
    output ghcb_pkg::entry_t rd_entry,
    output logic             full,
    output logic             not_empty
);

    ghcb_pkg::entry_t store_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_entry  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> hdl/ghcb_back.sv
// ----------------------------------------------------------------------------
// ghcb_back
// rolls the gear hash, counts the chunk and decides cuts
// ----------------------------------------------------------------------------
module ghcb_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  ghcb_pkg::cfg_t    cfg,
    input  logic              q_not_empty,
    input  ghcb_pkg::entry_t  entry,
    output logic              pop,
    ghcb_result_if.source     result
);

    logic [ghcb_pkg::HASH_W-1:0]      hash_reg, hash_next;
    logic [ghcb_pkg::LENGTH_BITS-1:0] len_reg, len_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_cut_reg;
    logic [ghcb_pkg::OUT_LEN_W-1:0]   out_len_reg;

    logic [ghcb_pkg::HASH_W-1:0]      h_base, h_new, top_mask;
    logic [ghcb_pkg::LENGTH_BITS-1:0] l_base, l_new;
    logic [63:0]                      l_wide;
    logic                             cut_now;

    assign pop = q_not_empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        h_base   = entry.restart ? '0 : hash_reg;
        l_base   = entry.restart ? '0 : len_reg;
        h_new    = {h_base[ghcb_pkg::HASH_W-2:0], 1'b0} + entry.gear_val;
        // counter saturates at all ones
        l_new    = (l_base != ghcb_pkg::LEN_MAX) ? l_base + 1'b1 : l_base;
        l_wide   = 64'(l_new);
        // a zero leading-bit count gives an empty mask, so the hash test always holds
        top_mask = ~({ghcb_pkg::HASH_W{1'b1}} >> cfg.lead_zeros);
        cut_now  = (l_wide >= 64'(cfg.max_length))
                || ((l_wide > 64'(cfg.min_length)) && ((h_new & top_mask) == '0));

        hash_next      = hash_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (pop)
        begin
            hash_next      = cut_now ? '0 : h_new;
            len_next       = cut_now ? '0 : l_new;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_cut_reg <= cut_now;
            out_len_reg <= l_wide[ghcb_pkg::OUT_LEN_W-1:0];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.cut          = out_cut_reg;
    assign result.chunk_length = out_len_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear hash chunk boundary testbench
// drives bytes, register writes and result backpressure into the chunker and
// checks every cut flag and chunk length against a gear hash predictor
// ----------------------------------------------------------------------------
module testbench;

    import ghcb_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int STALL_LIMIT   = 1000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int REPORT_LINES  = 40;

    typedef struct {
        logic                 cut;
        logic [OUT_LEN_W-1:0] chunk_length;
    } boundary_t;

    class chunk_scoreboard;
        logic [HASH_W-1:0]       gear_lut [GEAR_SIZE];
        logic [HASH_W-1:0]       hash_acc;
        logic [LENGTH_BITS-1:0]  len_acc;
        logic [31:0]             min_len;
        logic [31:0]             max_len;
        logic [LEAD_ZEROS_W-1:0] lead_zeros;
        boundary_t               expected_bounds[$];
        int                      errors;
        int                      bytes_in;
        int                      results_out;
        int                      cuts_out;

        function new();
            logic [HASH_W-1:0] s;
            logic [HASH_W-1:0] z;
            s = GEAR_GOLDEN;
            for (int k = 0; k < GEAR_SIZE; k++)
            begin
                s = s + GEAR_GOLDEN;
                z = s;
                z = (z ^ (z >> 30)) * GEAR_MIX1;
                z = (z ^ (z >> 27)) * GEAR_MIX2;
                gear_lut[k] = z ^ (z >> 31);
            end
            min_len     = RST_MIN_LENGTH;
            max_len     = RST_MAX_LENGTH;
            lead_zeros  = RST_LEAD_ZEROS;
            hash_acc    = '0;
            len_acc     = '0;
            errors      = 0;
            bytes_in    = 0;
            results_out = 0;
            cuts_out    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MIN_LENGTH: min_len    = value;
                CFG_MAX_LENGTH: max_len    = value;
                CFG_LEAD_ZEROS: lead_zeros = value[LEAD_ZEROS_W-1:0];
                default: ;
            endcase
        endfunction

        // roll one byte into the hash and queue the boundary it produces
        function void absorb_byte(logic [BYTE_W-1:0] b, logic r);
            boundary_t e;
            logic      hit;
            if (r)
            begin
                hash_acc = '0;
                len_acc  = '0;
            end
            hash_acc = (hash_acc << 1) + gear_lut[b];
            if (len_acc != LEN_MAX)
                len_acc = len_acc + 1'b1;
            hit = 1'b0;
            // forced cut takes priority over the content test
            if (len_acc >= max_len)
                hit = 1'b1;
            else if (len_acc > min_len)
            begin
                if (lead_zeros == 0)
                    hit = 1'b1;
                else if ((hash_acc >> (HASH_W - lead_zeros)) == 0)
                    hit = 1'b1;
            end
            e.cut          = hit;
            e.chunk_length = len_acc[OUT_LEN_W-1:0];
            expected_bounds.push_back(e);
            if (hit)
            begin
                hash_acc = '0;
                len_acc  = '0;
            end
            bytes_in++;
        endfunction

        task report_mismatch(string msg);
            if (errors < REPORT_LINES)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_boundary(logic got_cut, logic [OUT_LEN_W-1:0] got_len);
            boundary_t e;
            results_out++;
            if (expected_bounds.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: cut=%0b len=%0d",
                                          got_cut, got_len));
            end
            else
            begin
                e = expected_bounds.pop_front();
                if (got_cut !== e.cut)
                    report_mismatch($sformatf("result %0d cut=%0b, predicted %0b",
                                              results_out, got_cut, e.cut));
                if (got_len !== e.chunk_length)
                    report_mismatch($sformatf("result %0d chunk_length=%0d, predicted %0d",
                                              results_out, got_len, e.chunk_length));
                if (e.cut)
                    cuts_out++;
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    ghcb_byte_if   byte_ch ();
    ghcb_result_if res_ch ();
    ghcb_cfg_if    cfg_ch ();

    chunk_scoreboard sb;

    int  tx_gap_max;
    int  rx_gap_max;
    int  reg_writes;
    int  holds_done;
    bit  hold_req;

    gear_hash_chunk_boundary uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (byte_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic r);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.restart   <= r;
        @(negedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sb.absorb_byte(b, r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.value <= val;
        @(negedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sb.set_reg(idx, val);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] mn, input logic [31:0] mx,
                              input logic [LEAD_ZEROS_W-1:0] cb);
        write_reg(CFG_MIN_LENGTH, mn);
        write_reg(CFG_MAX_LENGTH, mx);
        write_reg(CFG_LEAD_ZEROS, {{(CFG_DATA_W-LEAD_ZEROS_W){1'b0}}, cb});
    endtask

    // stop offering bytes and let every pending result come out
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_bounds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] draw_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // result sink with random backpressure and one long hold-off on request
    initial
    begin : result_sink
        int                   gap;
        logic                 got_cut;
        logic [OUT_LEN_W-1:0] got_len;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(negedge clk);
            while (!res_ch.valid)
            begin
                @(posedge clk);
                @(negedge clk);
            end
            got_cut = res_ch.cut;
            got_len = res_ch.chunk_length;
            @(posedge clk);
            sb.check_boundary(got_cut, got_len);
        end
    end

    // ends the run when no channel has moved a transaction for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0]             mn;
        logic [31:0]             mx;
        logic [LEAD_ZEROS_W-1:0] cb;
        logic                    rs;
        sb         = new();
        tx_gap_max = 0;
        rx_gap_max = 0;
        reg_writes = 0;
        holds_done = 0;
        hold_req   = 1'b0;

        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.restart   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_MIN_LENGTH;
        cfg_ch.value      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // defaults after reset: long chunks, no cut expected
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        drain_results();

        // no leading bits tested: every byte past min_length cuts
        set_config(32'd2, 32'hFFFF_FFFF, 6'd0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        drain_results();

        // zero max length: each byte is a chunk of one
        write_reg(CFG_MAX_LENGTH, 32'd0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'h00, 1'b0);
        drain_results();

        // max below min: forced cut wins
        set_config(32'd10, 32'd3, 6'd1);
        send_byte(8'h33, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'hBB, 1'b1);
        send_byte(8'h99, 1'b0);
        drain_results();

        // one leading bit: frequent content cuts with a restart in the middle
        set_config(32'd1, 32'd6, 6'd1);
        send_byte(8'h21, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'h6B, 1'b1);
        send_byte(8'h94, 1'b0);
        drain_results();

        // all-ones registers
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_results();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    mn = $urandom_range(0, 32);
                    mx = mn + $urandom_range(1, 200);
                    cb = LEAD_ZEROS_W'($urandom_range(1, 6));
                end
                1:
                begin
                    mn = $urandom_range(0, 8);
                    mx = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                    cb = LEAD_ZEROS_W'($urandom_range(1, 4));
                end
                2:
                begin
                    mn = $urandom;
                    mx = $urandom_range(1, 24);
                    cb = LEAD_ZEROS_W'($urandom_range(0, 63));
                end
                default:
                begin
                    mn = $urandom_range(0, 12);
                    mx = $urandom_range(0, 16);
                    cb = LEAD_ZEROS_W'($urandom_range(0, 8));
                end
            endcase
            set_config(mn, mx, cb);

            // mix of back-to-back and gapped traffic on both sides
            tx_gap_max = (p % 3 == 0) ? 0 : 12;
            rx_gap_max = (p % 4 == 1) ? 0 : 12;
            if (p == 3)
                tx_gap_max = 0;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 3 && k == 20)
                    hold_req = 1'b1;
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain_results();
                rs = ($urandom_range(0, 19) == 0);
                send_byte(draw_byte(), rs);
            end
            drain_results();
        end

        if (sb.expected_bounds.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_bounds.size()));

        $display("run covered %0d bytes and %0d results (%0d chunk cuts)",
                 sb.bytes_in, sb.results_out, sb.cuts_out);
        $display("%0d register writes, %0d long result hold-offs, %0d mismatches",
                 reg_writes, holds_done, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
